// File: hw/rtl/mig_pkg.sv
// ----------------------------------------------------------------------------
// Mapped input glitch filter package
// Widths, register map constants and reset values shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package mig_pkg;

  localparam int NUM_EXPANDERS_DEF     = 4;
  localparam int PINS_PER_EXPANDER_DEF = 16;

  localparam int NUM_INPUTS = 64;
  localparam int IDX_W      = 6;
  localparam int NUM_W      = 7;
  localparam int EXP_W      = 2;
  localparam int PIN_MASK_W = 16;
  localparam int QUERY_W    = 8;
  localparam int MAP_W      = 48;
  localparam int NUM_REGS   = 8;
  localparam int REG_SEL_W  = 3;
  localparam int APB_AW     = 6;
  localparam int APB_DW     = 64;

  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  localparam logic [MAP_W-1:0] MAP_RESET [NUM_REGS] = '{
    48'd158644374628807, 48'd15602039525408,
    48'd176515802786767, 48'd60280607257258,
    48'd230130082999767, 48'd87087747896368,
    48'd248001511157727, 48'd131766315628218
  };

endpackage

`default_nettype wire

// File: hw/rtl/mig_item_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying snapshot reports and read queries.
// ----------------------------------------------------------------------------
`default_nettype none

interface mig_item_if;
  import mig_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [EXP_W-1:0]      expander_index;
  logic [PIN_MASK_W-1:0] changed_mask;
  logic [PIN_MASK_W-1:0] pin_values;
  logic [QUERY_W-1:0]    query_input;

  modport source (
    output valid, req_type, expander_index, changed_mask, pin_values, query_input,
    input  ready
  );

  modport sink (
    input  valid, req_type, expander_index, changed_mask, pin_values, query_input,
    output ready
  );

endinterface

`default_nettype wire

// File: hw/rtl/mig_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying filter events and query replies.
// ----------------------------------------------------------------------------
`default_nettype none

interface mig_result_if;
  import mig_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [NUM_W-1:0] input_number;
  logic             level;
  logic             last;

  modport source (
    output valid, kind, input_number, level, last,
    input  ready
  );

  modport sink (
    input  valid, kind, input_number, level, last,
    output ready
  );

endinterface

`default_nettype wire

// File: hw/rtl/mig_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mig_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/mig_cfg.sv
// ----------------------------------------------------------------------------
// Pin map registers
// APB-style register file holding the pin to input map of each expander.
// ----------------------------------------------------------------------------
`default_nettype none

module mig_cfg #(
  parameter int NUM_EXPANDERS = mig_pkg::NUM_EXPANDERS_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         psel,
  input  wire logic                                         penable,
  input  wire logic                                         pwrite,
  input  wire logic [mig_pkg::APB_AW-1:0]                   paddr,
  input  wire logic [mig_pkg::APB_DW-1:0]                   pwdata,
  output logic      [mig_pkg::APB_DW-1:0]                   prdata,
  output logic                                              pready,
  output logic      [2*NUM_EXPANDERS-1:0][mig_pkg::MAP_W-1:0] map
);
  import mig_pkg::*;

  localparam int NUM_MAP = 2 * NUM_EXPANDERS;

  logic [REG_SEL_W-1:0] sel;
  logic                 sel_ok;

  assign sel    = paddr[APB_AW-1:APB_AW-REG_SEL_W];
  assign sel_ok = {1'b0, sel} < (REG_SEL_W + 1)'(NUM_MAP);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MAP; i++) begin
        map[i] <= MAP_RESET[i];
      end
    end else if (psel && penable && pwrite && sel_ok) begin
      map[sel] <= pwdata[MAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_ok) begin
      prdata = {{(APB_DW-MAP_W){1'b0}}, map[sel]};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mig_scan.sv
// ----------------------------------------------------------------------------
// Pin scan engine
// Shifts a report one pin per step, updates the filters and answers queries.
// ----------------------------------------------------------------------------
`default_nettype none

module mig_scan #(
  parameter int NUM_EXPANDERS     = mig_pkg::NUM_EXPANDERS_DEF,
  parameter int PINS_PER_EXPANDER = mig_pkg::PINS_PER_EXPANDER_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire logic [2*NUM_EXPANDERS-1:0][mig_pkg::MAP_W-1:0] map,
  mig_item_if.sink                                            item,
  mig_result_if.source                                        result
);
  import mig_pkg::*;

  localparam int NUM_MAP   = 2 * NUM_EXPANDERS;
  localparam int MAP_SEL_W = (NUM_MAP > 1) ? $clog2(NUM_MAP) : 1;
  localparam int CNT_W     = $clog2(PINS_PER_EXPANDER + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_UPD   = 5'b00100,
    ST_LOOK  = 5'b01000,
    ST_QRY   = 5'b10000
  } state_t;

  state_t                   state;
  logic [PINS_PER_EXPANDER-1:0] mask_sr;
  logic [PINS_PER_EXPANDER-1:0] val_sr;
  logic [2*MAP_W-1:0]       map_sr;
  logic [CNT_W-1:0]         cnt;
  logic [IDX_W-1:0]         idx;
  logic                     sample;
  logic                     q_ok;
  logic [NUM_W-1:0]         q_num;
  logic                     pend_valid;
  logic [NUM_W-1:0]         pend_num;
  logic                     pend_level;
  logic                     out_valid;
  logic                     out_kind;
  logic [NUM_W-1:0]         out_num;
  logic                     out_level;
  logic                     out_last;
  logic [NUM_INPUTS-1:0]    vld;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_raddr;
  logic [1:0]               ram_wdata;
  logic [1:0]               ram_rdata;
  logic [1:0]               entry;
  logic                     filt_next;
  logic                     change;
  logic                     slot_free;
  logic                     upd_go;
  logic [2:0]               map_sel;
  logic                     exp_ok;

  assign slot_free = !out_valid || result.ready;
  assign entry     = vld[idx] ? ram_rdata : 2'b00;
  assign filt_next = sample ? (entry[1] || entry[0]) && (entry[1] || !entry[0]) ?
                     (entry[1] ? 1'b1 : entry[0]) : entry[0] : 1'b0;
  assign change    = filt_next != entry[0];
  assign upd_go    = (state == ST_UPD) && (!change || !pend_valid || slot_free);
  assign ram_we    = upd_go;
  assign ram_wdata = {sample, filt_next};
  assign ram_raddr = (state == ST_SCAN) ? map_sr[IDX_W-1:0] : idx;
  assign map_sel   = {item.expander_index, 1'b0};
  assign exp_ok    = {1'b0, item.expander_index} < (EXP_W + 1)'(NUM_EXPANDERS);

  assign item.ready          = (state == ST_IDLE);
  assign result.valid        = out_valid;
  assign result.kind         = out_kind;
  assign result.input_number = out_num;
  assign result.level        = out_level;
  assign result.last         = out_last;

  mig_ram #(
    .WIDTH (2),
    .DEPTH (NUM_INPUTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      vld        <= '0;
    end else begin
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            if (item.req_type == REQ_QUERY) begin
              state <= ST_LOOK;
            end else if (exp_ok) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (cnt == '0) begin
            if (!pend_valid) begin
              state <= ST_IDLE;
            end else if (slot_free) begin
              out_valid  <= 1'b1;
              out_kind   <= KIND_EVENT;
              out_num    <= pend_num;
              out_level  <= pend_level;
              out_last   <= 1'b1;
              pend_valid <= 1'b0;
              state      <= ST_IDLE;
            end
          end else if (mask_sr[0]) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (upd_go) begin
            vld[idx] <= 1'b1;
            state    <= ST_SCAN;
            if (change) begin
              if (pend_valid) begin
                out_valid <= 1'b1;
                out_kind  <= KIND_EVENT;
                out_num   <= pend_num;
                out_level <= pend_level;
                out_last  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_num   <= {1'b0, idx} + NUM_W'(1);
              pend_level <= filt_next;
            end
          end
        end
        ST_LOOK: begin
          state <= ST_QRY;
        end
        ST_QRY: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_REPLY;
            out_num   <= q_ok ? q_num : '0;
            out_level <= q_ok ? entry[1] : 1'b0;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item.valid) begin
      mask_sr <= item.changed_mask[PINS_PER_EXPANDER-1:0];
      val_sr  <= item.pin_values[PINS_PER_EXPANDER-1:0];
      map_sr  <= {map[map_sel[MAP_SEL_W-1:0] + MAP_SEL_W'(1)], map[map_sel[MAP_SEL_W-1:0]]};
      cnt     <= CNT_W'(PINS_PER_EXPANDER);
      idx     <= item.query_input[IDX_W-1:0] - IDX_W'(1);
      q_num   <= item.query_input[NUM_W-1:0];
      q_ok    <= (item.query_input != '0) &&
                 (item.query_input <= QUERY_W'(NUM_INPUTS));
    end else if (state == ST_SCAN && cnt != '0) begin
      mask_sr <= mask_sr >> 1;
      val_sr  <= val_sr >> 1;
      map_sr  <= map_sr >> IDX_W;
      cnt     <= cnt - CNT_W'(1);
      if (mask_sr[0]) begin
        idx    <= map_sr[IDX_W-1:0];
        sample <= val_sr[0];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mapped_input_glitch_filter_core.sv
// ----------------------------------------------------------------------------
// Mapped input glitch filter core
// The item channel takes expander snapshot reports and raw level queries.
// Each reported pin is mapped through the APB pin map to one of 64 inputs.
// A per-input filter rises after two high samples in a row and falls on the
// first low sample; every filter change leaves on the result channel as an
// event, the final result of a request carrying last.
// A report is accepted, then the pin shift registers step through the pins;
// each masked pin adds a read then a write of the filter RAM, and a final
// step closes the scan. A query is accepted, reads the RAM, then replies.
// One event is held back until the scan knows whether another follows, so
// the last flag is exact. A stalled receiver holds the output register; the
// scan stops when a further event or the held final event needs the output,
// and a query reply waits for it as well.
// Reset restores the stock map and clears all filter state at once through
// per-input valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module mapped_input_glitch_filter_core #(
  parameter int NUM_EXPANDERS     = mig_pkg::NUM_EXPANDERS_DEF,
  parameter int PINS_PER_EXPANDER = mig_pkg::PINS_PER_EXPANDER_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mig_pkg::APB_AW-1:0] paddr,
  input  wire logic [mig_pkg::APB_DW-1:0] pwdata,
  output logic      [mig_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  mig_item_if.sink                        item,
  mig_result_if.source                    result
);
  import mig_pkg::*;

  logic [2*NUM_EXPANDERS-1:0][MAP_W-1:0] map;

  mig_cfg #(
    .NUM_EXPANDERS (NUM_EXPANDERS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .map     (map)
  );

  mig_scan #(
    .NUM_EXPANDERS     (NUM_EXPANDERS),
    .PINS_PER_EXPANDER (PINS_PER_EXPANDER)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .map    (map),
    .item   (item),
    .result (result)
  );

endmodule

`default_nettype wire

// File: hw/rtl/mig_checker.sv
// ----------------------------------------------------------------------------
// Mapped input glitch filter checker
// Port-level properties of the result channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module mig_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        res_valid,
  input wire logic                        res_ready,
  input wire logic                        res_kind,
  input wire logic [mig_pkg::NUM_W-1:0]   res_num,
  input wire logic                        res_level,
  input wire logic                        res_last
);
  import mig_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_num) && $stable(res_last))
    else $error("result changed while stalled");

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_REPLY |-> res_last)
    else $error("query reply without last");

  a_event_num: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_EVENT |-> res_num != '0 && res_num <= NUM_W'(NUM_INPUTS))
    else $error("event input number out of range");

  a_bad_read: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_REPLY && res_num == '0 |-> !res_level)
    else $error("out-of-range read with nonzero level");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind mapped_input_glitch_filter_core mig_checker u_mig_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_kind  (result.kind),
  .res_num   (result.input_number),
  .res_level (result.level),
  .res_last  (result.last)
);

`default_nettype wire
